// ----- sv/txq_pkg.sv -----
// Shared types and constants for the transmit queue with receipt timeout.
package txq_pkg;

	localparam int QDEPTH = 16;
	localparam int PTR_W  = $clog2(QDEPTH);
	localparam int CNT_W  = $clog2(QDEPTH + 1);

	localparam logic [15:0] TIMEOUT_RESET = 16'd200;

	localparam logic [1:0] REQ_ENQ  = 2'd0;
	localparam logic [1:0] REQ_RCPT = 2'd1;
	localparam logic [1:0] REQ_TICK = 2'd2;

	localparam logic [1:0] EV_ENQ  = 2'd0;
	localparam logic [1:0] EV_RCPT = 2'd1;
	localparam logic [1:0] EV_LOST = 2'd2;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [28:0] frame_id;
		logic [3:0]  frame_len;
		logic [63:0] frame_data;
	} req_t;

	typedef struct packed {
		logic [1:0]  event_kind;
		logic        send_valid;
		logic [28:0] send_id;
		logic [3:0]  send_len;
		logic [63:0] send_payload;
		logic        lost_valid;
		logic [28:0] lost_id;
		logic [3:0]  lost_len;
		logic [63:0] lost_payload;
		logic        dropped_full;
	} rsp_t;

	typedef struct packed {
		logic [28:0] id;
		logic [3:0]  len;
		logic [63:0] payload;
	} entry_t;

endpackage

// ----- sv/tx_queue_with_receipt_timeout_top.sv -----
// Transmit queue, one frame in flight, with receipt timeout: top level.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------
//  req     | req_valid/req_stall  | req_t, one request
//  rsp     | rsp_valid/rsp_stall  | rsp_t, one answer
//  cfg     | cfg_valid/cfg_ready  | cfg_data, timeout
//
// One request per cycle unless a held answer stalls: the head frame sits in a
// register and the entry behind it is read straight from the store, so a
// request is finished in the cycle it is taken and its answer is presented from
// the next cycle. Ticks that do not expire give no beat.
// req_stall is high only while a held answer is stalled. cfg_ready is always
// high. Reset empties the queue, stops the timer and sets the timeout to 200.
module tx_queue_with_receipt_timeout_top
	import txq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  req_t        req,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output rsp_t        rsp,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	entry_t             store_q [QDEPTH];
	entry_t             head_ent_q;
	logic [PTR_W-1:0]   head_q;
	logic [CNT_W-1:0]   count_q;
	logic [15:0]        timer_q;
	logic               run_q;
	logic [15:0]        timeout_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	entry_t             head_ent_d;
	logic [PTR_W-1:0]   head_d;
	logic [CNT_W-1:0]   count_d;
	logic [15:0]        timer_d;
	logic               run_d;
	rsp_t               res;
	logic               res_vld;
	logic               wr_en;
	logic               fire;
	logic [PTR_W:0]     tail_sum;
	logic [PTR_W-1:0]   tail;
	logic [PTR_W-1:0]   nxt;
	entry_t             nxt_ent;
	entry_t             in_ent;

	assign req_stall = rsp_valid_q & rsp_stall;
	assign fire      = req_valid & ~req_stall;
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign tail_sum = {1'b0, head_q} + {1'b0, count_q[PTR_W-1:0]};
	assign tail     = (tail_sum >= (PTR_W+1)'(QDEPTH)) ?
		PTR_W'(tail_sum - (PTR_W+1)'(QDEPTH)) : tail_sum[PTR_W-1:0];
	assign nxt      = (head_q == PTR_W'(QDEPTH - 1)) ? '0 : head_q + 1'b1;
	assign nxt_ent  = store_q[nxt];
	assign in_ent   = '{id: req.frame_id, len: req.frame_len, payload: req.frame_data};

	always_comb begin
		head_ent_d = head_ent_q;
		head_d     = head_q;
		count_d    = count_q;
		timer_d    = timer_q;
		run_d      = run_q;
		res        = '0;
		res_vld    = 1'b0;
		wr_en      = 1'b0;
		unique case (req.req_type)
			REQ_ENQ: begin
				res_vld        = 1'b1;
				res.event_kind = EV_ENQ;
				if (count_q == CNT_W'(QDEPTH)) begin
					res.dropped_full = 1'b1;
				end else begin
					wr_en   = 1'b1;
					count_d = count_q + 1'b1;
					if (count_q == '0) begin
						timer_d          = timeout_q;
						run_d            = 1'b1;
						head_ent_d       = in_ent;
						res.send_valid   = 1'b1;
						res.send_id      = in_ent.id;
						res.send_len     = in_ent.len;
						res.send_payload = in_ent.payload;
					end
				end
			end
			REQ_RCPT: begin
				res_vld        = 1'b1;
				res.event_kind = EV_RCPT;
				if (count_q != '0) begin
					head_d  = nxt;
					count_d = count_q - 1'b1;
					timer_d = '0;
					run_d   = 1'b0;
					if (count_q > CNT_W'(1)) begin
						timer_d          = timeout_q;
						run_d            = 1'b1;
						head_ent_d       = nxt_ent;
						res.send_valid   = 1'b1;
						res.send_id      = nxt_ent.id;
						res.send_len     = nxt_ent.len;
						res.send_payload = nxt_ent.payload;
					end
				end
			end
			REQ_TICK: begin
				if (run_q) begin
					if (timer_q > 16'd1) begin
						timer_d = timer_q - 16'd1;
					end else begin
						timer_d        = '0;
						run_d          = 1'b0;
						res_vld        = 1'b1;
						res.event_kind = EV_LOST;
						if (count_q != '0) begin
							res.lost_valid   = 1'b1;
							res.lost_id      = head_ent_q.id;
							res.lost_len     = head_ent_q.len;
							res.lost_payload = head_ent_q.payload;
							head_d           = nxt;
							count_d          = count_q - 1'b1;
						end
						if (count_q > CNT_W'(1)) begin
							timer_d          = timeout_q;
							run_d            = 1'b1;
							head_ent_d       = nxt_ent;
							res.send_valid   = 1'b1;
							res.send_id      = nxt_ent.id;
							res.send_len     = nxt_ent.len;
							res.send_payload = nxt_ent.payload;
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			count_q     <= '0;
			timer_q     <= '0;
			run_q       <= 1'b0;
			timeout_q   <= TIMEOUT_RESET;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				timeout_q <= cfg_data;
			end
			if (fire) begin
				head_q  <= head_d;
				count_q <= count_d;
				timer_q <= timer_d;
				run_q   <= run_d;
			end
			if (!req_stall) begin
				rsp_valid_q <= fire & res_vld;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			head_ent_q <= head_ent_d;
		end
		if (fire && wr_en) begin
			store_q[tail] <= in_ent;
		end
		if (!req_stall) begin
			rsp_q <= res;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QDEPTH))
		else $error("queue count above depth");

	a_run_needs_frame: assert property (@(posedge clk) disable iff (!arst_n)
		run_q |-> (count_q != '0))
		else $error("timer running with empty queue");

	a_enq_empty_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && req.req_type == REQ_ENQ && count_q == '0) |=>
		(run_q && count_q == CNT_W'(1) && rsp_valid_q && rsp_q.send_valid))
		else $error("enqueue into empty queue did not start a send");

	a_full_drops: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && req.req_type == REQ_ENQ && count_q == CNT_W'(QDEPTH)) |=>
		(count_q == CNT_W'(QDEPTH) && rsp_q.dropped_full))
		else $error("enqueue into full queue was not dropped");

	a_stall_only_when_held: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid_q |-> !req_stall)
		else $error("request stalled with no answer held");

endmodule
